/* src/crcfr_pkg.sv */
// ----------------------------------------------------------------------------
// crcfr_pkg: shared constants and types of the checked frame receiver
// Frame heads, length limits, store geometry and the CRC unit controls.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int STATUS_BYTES = 13;
  localparam int FRAME_BYTES  = 20;

  localparam int IDX_W  = $clog2(FRAME_BYTES);
  localparam int WPOS_W = 5;
  localparam int SIDX_W = 4;

  // Bytes covered by the CRC; the last two store bytes hold the check value.
  localparam int CRC_BYTES    = FRAME_BYTES - 2;
  localparam int STATUS_START = 5;

  localparam logic [7:0]  HEAD_CONTROL = 8'hC7;
  localparam logic [7:0]  HEAD_CONFIG  = 8'hAD;
  localparam logic [7:0]  LEN_MIN      = 8'd3;
  localparam logic [7:0]  LEN_MAX      = 8'd20;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_TOP      = 16'h8000;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_CONTROL = 2'd1;
  localparam logic [1:0] KIND_CONFIG  = 2'd2;

  localparam logic EV_STATUS  = 1'b0;
  localparam logic EV_CRC_ERR = 1'b1;

  typedef struct packed {
    logic clear;
    logic en;
  } crc_ctrl_t;

endpackage

/* src/crcfr_crc_unit.sv */
// ----------------------------------------------------------------------------
// crcfr_crc_unit: CRC-16 accumulator
// Folds one byte per cycle, while enabled, into a CRC-16 (poly 0x1021, MSB first) register.
// ----------------------------------------------------------------------------
module crcfr_crc_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crcfr_pkg::crc_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  output logic [15:0]         crc_o
);
  import crcfr_pkg::*;

  logic [15:0] crc_q, crc_d;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    logic [15:0] cur;
    c   = crc_in;
    cur = {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (((c ^ cur) & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
      cur = {cur[14:0], 1'b0};
    end
    return c;
  endfunction

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.clear) begin
      crc_d = 16'h0000;
    end else if (ctrl_i.en) begin
      crc_d = crc_byte(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'h0000;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

/* src/crc_checked_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_top: serial deframer with CRC-16/XMODEM check
// Hunts for frame heads, stores frame bytes and reports status or CRC errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
//   byte per item. Most bytes are absorbed directly: ready stays high and a
//   new item can be taken every cycle.
//   The second CRC byte of a control frame starts the check. The block then
//   drops ready, walks store bytes 0..17 through the CRC unit at one byte
//   per cycle, compares in the check state, and emits either 13 status
//   items or one CRC error item on the output channel (out_valid_o /
//   out_ready_i), one item per cycle while the receiver takes them.
//   A stalled receiver simply holds the current output item; the sequencer
//   waits and no item is lost. Ready comes back the cycle after the last
//   item is taken.
//   Reset returns the hunt to the head phase and clears the write position,
//   frame kind and whole frame store to zero; the block is ready after reset.
//   Config frames are swallowed without any output item.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       event_kind_o,
  output logic [7:0] status_byte_o,
  output logic [3:0] status_index_o,
  output logic       keep_as_last_on_o,
  output logic       last_of_run_o
);
  import crcfr_pkg::*;

  // Frame hunt phase, one-hot.
  typedef enum logic [4:0] {
    PH_HEAD    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CRC0    = 5'b01000,
    PH_CRC1    = 5'b10000
  } phase_e;

  // Sequencer state, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_EMIT  = 4'b1000
  } seq_e;

  phase_e phase_q, phase_d;
  seq_e   seq_q, seq_d;

  logic [WPOS_W-1:0] wpos_q, wpos_d;
  logic [1:0]        kind_q, kind_d;
  logic [7:0]        store_q [FRAME_BYTES];

  logic [IDX_W-1:0]  walk_cnt_q, walk_cnt_d;
  logic [SIDX_W-1:0] sidx_q, sidx_d;
  logic              keep_q, keep_d;
  logic              done_q, done_d;   // last output item already loaded

  logic       out_valid_q, out_valid_d;
  logic       ev_q, ev_d;
  logic [7:0] sbyte_q, sbyte_d;
  logic [3:0] sindex_q, sindex_d;
  logic       okeep_q, okeep_d;
  logic       olast_q, olast_d;

  logic             in_fire;
  logic             wr_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic [WPOS_W-1:0] wpos_inc;
  crc_ctrl_t        crc_ctrl;
  logic [15:0]      crc_val;
  logic             load_slot;

  assign in_ready_o = (seq_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wpos_inc   = wpos_q + WPOS_W'(1);

  // Single read port of the store, shared by the CRC walk and status emission.
  always_comb begin
    if (seq_q == ST_EMIT) begin
      rd_addr = IDX_W'(STATUS_START) + IDX_W'(sidx_q);
    end else begin
      rd_addr = walk_cnt_q;
    end
  end
  assign rd_data = store_q[rd_addr];

  // Frame hunt: one received byte per accepted item.
  always_comb begin
    phase_d = phase_q;
    wpos_d  = wpos_q;
    kind_d  = kind_q;
    wr_en   = 1'b0;
    if (in_fire) begin
      case (phase_q)
        PH_HEAD: begin
          if (rx_byte_i == HEAD_CONTROL || rx_byte_i == HEAD_CONFIG) begin
            wr_en   = 1'b1;
            wpos_d  = wpos_inc;
            kind_d  = (rx_byte_i == HEAD_CONTROL) ? KIND_CONTROL : KIND_CONFIG;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (rx_byte_i >= LEN_MIN && rx_byte_i <= LEN_MAX) begin
            wr_en   = 1'b1;
            wpos_d  = wpos_inc;
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_HEAD;
            wpos_d  = '0;
            kind_d  = KIND_NONE;
          end
        end
        PH_PAYLOAD: begin
          wr_en  = 1'b1;
          wpos_d = wpos_inc;
          // Store byte 1 holds the frame length for the whole payload.
          if (8'(wpos_inc) == store_q[1]) begin
            if (kind_q == KIND_CONTROL) begin
              phase_d = PH_CRC0;
            end else begin
              phase_d = PH_HEAD;
              wpos_d  = '0;
              kind_d  = KIND_NONE;
            end
          end
        end
        PH_CRC0: begin
          wr_en   = 1'b1;
          wpos_d  = wpos_inc;
          phase_d = PH_CRC1;
        end
        PH_CRC1: begin
          wr_en   = 1'b1;
          phase_d = PH_HEAD;
          wpos_d  = '0;
          kind_d  = KIND_NONE;
        end
        default: begin
          phase_d = PH_HEAD;
          wpos_d  = '0;
          kind_d  = KIND_NONE;
        end
      endcase
    end
  end

  // Sequencer: CRC walk, compare, emission.
  assign load_slot = !out_valid_q || out_ready_i;

  always_comb begin
    seq_d       = seq_q;
    walk_cnt_d  = walk_cnt_q;
    sidx_d      = sidx_q;
    keep_d      = keep_q;
    done_d      = done_q;
    crc_ctrl    = '{clear: 1'b0, en: 1'b0};
    out_valid_d = out_valid_q && !out_ready_i;
    ev_d        = ev_q;
    sbyte_d     = sbyte_q;
    sindex_d    = sindex_q;
    okeep_d     = okeep_q;
    olast_d     = olast_q;
    case (seq_q)
      ST_IDLE: begin
        if (in_fire && phase_q == PH_CRC1) begin
          seq_d          = ST_WALK;
          walk_cnt_d     = '0;
          crc_ctrl.clear = 1'b1;
        end
      end
      ST_WALK: begin
        crc_ctrl.en = 1'b1;
        walk_cnt_d  = walk_cnt_q + IDX_W'(1);
        if (walk_cnt_q == IDX_W'(CRC_BYTES - 1)) begin
          seq_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Output register is empty here: the previous run fully drained.
        if (crc_val[15:8] == store_q[FRAME_BYTES-2] &&
            crc_val[7:0] == store_q[FRAME_BYTES-1]) begin
          keep_d = (store_q[STATUS_START] == 8'd2) &&
                   (store_q[STATUS_START+1] > 8'd1);
          sidx_d = '0;
          done_d = 1'b0;
        end else begin
          out_valid_d = 1'b1;
          ev_d        = EV_CRC_ERR;
          sbyte_d     = 8'h00;
          sindex_d    = 4'd0;
          okeep_d     = 1'b0;
          olast_d     = 1'b1;
          done_d      = 1'b1;
        end
        seq_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (done_q) begin
          // Hold until the last item leaves the output register.
          if (!out_valid_q || out_ready_i) begin
            seq_d = ST_IDLE;
          end
        end else if (load_slot) begin
          out_valid_d = 1'b1;
          ev_d        = EV_STATUS;
          sbyte_d     = rd_data;
          sindex_d    = 4'(sidx_q);
          okeep_d     = keep_q;
          olast_d     = (sidx_q == SIDX_W'(STATUS_BYTES - 1));
          sidx_d      = sidx_q + SIDX_W'(1);
          if (sidx_q == SIDX_W'(STATUS_BYTES - 1)) begin
            done_d = 1'b1;
          end
        end
      end
      default: begin
        seq_d = ST_IDLE;
      end
    endcase
  end

  crcfr_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (rd_data),
    .crc_o  (crc_val)
  );

  // Frame store: cleared at reset, writes past the store are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_q[i] <= 8'h00;
      end
    end else if (wr_en && (int'(wpos_q) < FRAME_BYTES)) begin
      store_q[IDX_W'(wpos_q)] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      seq_q       <= ST_IDLE;
      wpos_q      <= '0;
      kind_q      <= KIND_NONE;
      walk_cnt_q  <= '0;
      sidx_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      wpos_q      <= wpos_d;
      kind_q      <= kind_d;
      walk_cnt_q  <= walk_cnt_d;
      sidx_q      <= sidx_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    keep_q   <= keep_d;
    ev_q     <= ev_d;
    sbyte_q  <= sbyte_d;
    sindex_q <= sindex_d;
    okeep_q  <= okeep_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o       = out_valid_q;
  assign event_kind_o      = ev_q;
  assign status_byte_o     = sbyte_q;
  assign status_index_o    = sindex_q;
  assign keep_as_last_on_o = okeep_q;
  assign last_of_run_o     = olast_q;

endmodule

/* src/crcfr_checker.sv */
// ----------------------------------------------------------------------------
// crcfr_checker: port-level checks of the checked frame receiver
// Watches the top level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module crcfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       event_kind_o,
  input logic [7:0] status_byte_o,
  input logic [3:0] status_index_o,
  input logic       keep_as_last_on_o,
  input logic       last_of_run_o
);
  import crcfr_pkg::*;

  // Hold a stalled output item: valid, kind, byte and index stay unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_byte_o) &&
    $stable(status_index_o) && $stable(event_kind_o))
    else $error("output item changed while stalled");

  // Never take a byte while results are pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output item pending");

  // A CRC error item is a lone, zeroed, final item.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_CRC_ERR |->
    last_of_run_o && status_byte_o == 8'h00 && status_index_o == 4'd0 &&
    !keep_as_last_on_o)
    else $error("malformed CRC error item");

  // Return to accepting bytes right after the final item of a run leaves.
  a_ready_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_of_run_o |=> in_ready_o)
    else $error("ready did not return after last item");

endmodule

bind crc_checked_frame_receiver_top crcfr_checker u_crcfr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .event_kind_o      (event_kind_o),
  .status_byte_o     (status_byte_o),
  .status_index_o    (status_index_o),
  .keep_as_last_on_o (keep_as_last_on_o),
  .last_of_run_o     (last_of_run_o)
);

/* verif/crc_checked_frame_receiver_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_top_test: self-checking bench for the deframer
// Drives received bytes through the valid/ready input and predicts every
// status or CRC error item with a local deframer and CRC-16/XMODEM model.
// A short table of directed bytes comes first. Random frames follow: most
// often well-formed control frames, plus short control frames, config
// frames, bad lengths and noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_top_test;
  import crcfr_pkg::*;

  localparam int IDLE_PCT         = 36;
  localparam int RANDOM_ITEMS     = 380;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 64;
  localparam int NUM_DIRECTED     = 18;

  // One item on the output channel, in port order.
  typedef struct packed {
    logic       event_kind;
    logic [7:0] status_byte;
    logic [3:0] status_index;
    logic       keep_as_last_on;
    logic       last_of_run;
  } status_event_t;

  // One directed byte; a typed event replaces the prediction on its row.
  typedef struct packed {
    logic [7:0]    rx;
    logic          has_typed;
    status_event_t typed;
  } dir_row_t;

  typedef enum logic [2:0] {
    HUNT_HEAD, HUNT_LEN, HUNT_PAYLOAD, HUNT_CRC0, HUNT_CRC1
  } hunt_phase_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       event_kind_o;
  logic [7:0] status_byte_o;
  logic [3:0] status_index_o;
  logic       keep_as_last_on_o;
  logic       last_of_run_o;

  crc_checked_frame_receiver_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_kind_o      (event_kind_o),
    .status_byte_o     (status_byte_o),
    .status_index_o    (status_index_o),
    .keep_as_last_on_o (keep_as_last_on_o),
    .last_of_run_o     (last_of_run_o)
  );

  // Deframer model state: phase, write position, frame kind and the store.
  hunt_phase_e   mdl_phase;
  logic [4:0]    mdl_wpos;
  logic [1:0]    mdl_kind;
  logic [7:0]    mdl_store [FRAME_BYTES];

  status_event_t fresh_events [$];   // events caused by the latest byte
  status_event_t pending_events [$]; // events still owed by the block
  int            mismatch_count;
  int            items_sent;

  // Shared between the two sides: a stretch with no idling, and a request
  // for one long receiver hold-off.
  logic          no_gaps;
  logic          long_hold_req;
  logic          long_hold_done;

  // Directed bytes. Each special case walks the hunt logic once; the closing
  // byte of the short control frame has a known CRC error, since the store
  // holds only C7 03 and zeros and its last two bytes are still zero.
  dir_row_t dir_rows [NUM_DIRECTED] = '{
    '{8'h00, 1'b0, '0},                                  // ignored while hunting
    '{8'hFF, 1'b0, '0},                                  // ignored while hunting
    '{HEAD_CONTROL, 1'b0, '0},
    '{8'h02, 1'b0, '0},                                  // length below range
    '{HEAD_CONFIG, 1'b0, '0},
    '{8'h15, 1'b0, '0},                                  // length above range
    '{HEAD_CONTROL, 1'b0, '0},
    '{8'hFF, 1'b0, '0},                                  // largest bad length
    '{HEAD_CONFIG, 1'b0, '0},
    '{8'h00, 1'b0, '0},                                  // zero length
    '{HEAD_CONFIG, 1'b0, '0},                            // shortest config frame
    '{8'h03, 1'b0, '0},
    '{8'h5A, 1'b0, '0},                                  // config frame dropped
    '{HEAD_CONTROL, 1'b0, '0},                           // shortest control frame
    '{8'h03, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},                                  // first CRC byte
    '{8'h00, 1'b1, '{EV_CRC_ERR, 8'h00, 4'h0, 1'b0, 1'b1}}
  };

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // One byte through CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] acc;
    logic [15:0] cur;
    acc = crc;
    cur = {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (((acc ^ cur) & CRC_TOP) != 16'h0000) acc = (acc << 1) ^ CRC_POLY;
      else acc = acc << 1;
      cur = cur << 1;
    end
    return acc;
  endfunction

  // Store at the write position; bytes past the store are dropped but the
  // position still advances.
  function automatic void put_in_store(input logic [7:0] b);
    if (mdl_wpos < FRAME_BYTES) mdl_store[mdl_wpos] = b;
    mdl_wpos = mdl_wpos + 5'd1;
  endfunction

  function automatic void restart_hunt();
    mdl_phase = HUNT_HEAD;
    mdl_wpos  = '0;
    mdl_kind  = KIND_NONE;
  endfunction

  function automatic void reset_deframer();
    restart_hunt();
    for (int i = 0; i < FRAME_BYTES; i++) mdl_store[i] = 8'h00;
  endfunction

  // Advance the model by one received byte and leave its events in
  // fresh_events.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [15:0] crc;
    logic        keep;
    fresh_events.delete();
    case (mdl_phase)
      HUNT_HEAD: begin
        if (b == HEAD_CONTROL || b == HEAD_CONFIG) begin
          put_in_store(b);
          mdl_kind  = (b == HEAD_CONTROL) ? KIND_CONTROL : KIND_CONFIG;
          mdl_phase = HUNT_LEN;
        end
      end
      HUNT_LEN: begin
        if (b >= LEN_MIN && b <= LEN_MAX) begin
          put_in_store(b);
          mdl_phase = HUNT_PAYLOAD;
        end else begin
          restart_hunt();
        end
      end
      HUNT_PAYLOAD: begin
        put_in_store(b);
        if ({3'b000, mdl_wpos} == mdl_store[1]) begin
          if (mdl_kind == KIND_CONTROL) mdl_phase = HUNT_CRC0;
          else restart_hunt();
        end
      end
      HUNT_CRC0: begin
        put_in_store(b);
        mdl_phase = HUNT_CRC1;
      end
      HUNT_CRC1: begin
        put_in_store(b);
        restart_hunt();
        crc = 16'h0000;
        for (int i = 0; i < CRC_BYTES; i++) crc = crc16_update(crc, mdl_store[i]);
        if (crc == {mdl_store[FRAME_BYTES-2], mdl_store[FRAME_BYTES-1]}) begin
          keep = (mdl_store[STATUS_START] == 8'd2) && (mdl_store[STATUS_START+1] > 8'd1);
          for (int i = 0; i < STATUS_BYTES; i++) begin
            fresh_events.push_back('{EV_STATUS, mdl_store[STATUS_START+i], i[3:0],
                                     keep, (i == STATUS_BYTES - 1)});
          end
        end else begin
          fresh_events.push_back('{EV_CRC_ERR, 8'h00, 4'h0, 1'b0, 1'b1});
        end
      end
      default: restart_hunt();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one byte from the next falling edge, idling at random first, and
  // hold it until the block takes it. Owed events come from the model unless
  // the directed table types them in.
  task automatic send_byte(input logic [7:0] b, input logic use_typed,
                           input status_event_t typed_ev);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_byte(b);
    if (use_typed) pending_events.push_back(typed_ev);
    else foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
    items_sent++;
  endtask

  // Build and send one frame. A good control frame of length 18..20 carries
  // the CRC of bytes 0..17 in positions 18 and 19, wherever the length puts
  // them; corrupt flips one bit after the length byte.
  task automatic send_frame(input logic [7:0] head, input int len,
                            input logic good, input logic corrupt);
    logic [7:0]  img [24];
    logic [15:0] crc;
    int          total;
    int          pos;
    img[0] = head;
    img[1] = len[7:0];
    for (int i = 2; i < 24; i++) img[i] = 8'($urandom_range(0, 255));
    // Steer the last-on flag often enough to see both values.
    if ($urandom_range(0, 99) < 40) begin
      img[5] = 8'd2;
      case ($urandom_range(0, 3))
        0:       img[6] = 8'd0;
        1:       img[6] = 8'd1;
        2:       img[6] = 8'd2;
        default: img[6] = 8'($urandom_range(0, 255));
      endcase
    end
    total = (head == HEAD_CONTROL) ? len + 2 : len;
    if (good) begin
      crc = 16'h0000;
      for (int i = 0; i < CRC_BYTES; i++) crc = crc16_update(crc, img[i]);
      img[FRAME_BYTES-2] = crc[15:8];
      img[FRAME_BYTES-1] = crc[7:0];
    end
    if (corrupt) begin
      pos = $urandom_range(2, total - 1);
      img[pos] = img[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < total; i++) send_byte(img[i], 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Clock, limit and receiver
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous bound: a correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("crc_checked_frame_receiver_top_test: FAIL");
    $finish;
  end

  // Receiver: random stalls, no stalls during the quiet stretch, and one long
  // hold-off counted here so that the block backs up into its input.
  initial begin
    out_ready_i    = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else if (no_gaps) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare every accepted output item with the oldest owed event.
  always @(posedge clk_i) begin : check_events
    status_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected item kind=%0b byte=%h index=%0d keep=%0b last=%0b",
                 $time, event_kind_o, status_byte_o, status_index_o,
                 keep_as_last_on_o, last_of_run_o);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.event_kind) begin
          $display("%0t: event_kind expected %0b got %0b",
                   $time, want.event_kind, event_kind_o);
          mismatch_count++;
        end
        if (status_byte_o !== want.status_byte) begin
          $display("%0t: status_byte expected %h got %h",
                   $time, want.status_byte, status_byte_o);
          mismatch_count++;
        end
        if (status_index_o !== want.status_index) begin
          $display("%0t: status_index expected %0d got %0d",
                   $time, want.status_index, status_index_o);
          mismatch_count++;
        end
        if (keep_as_last_on_o !== want.keep_as_last_on) begin
          $display("%0t: keep_as_last_on expected %0b got %0b",
                   $time, want.keep_as_last_on, keep_as_last_on_o);
          mismatch_count++;
        end
        if (last_of_run_o !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0b got %0b",
                   $time, want.last_of_run, last_of_run_o);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int pick;
    int random_sent;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    no_gaps        = 1'b0;
    long_hold_req  = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    reset_deframer();

    // Hold reset, then release it away from the rising edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_byte(dir_rows[r].rx, dir_rows[r].has_typed, dir_rows[r].typed);
    end

    // Random part: control frames with random content, most often well-formed.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      // Long receiver hold-off over a good frame: the closing byte starts the
      // check, the output backs up, and the next bytes wait at the input.
      if (random_sent >= 100 && !long_hold_req) begin
        long_hold_req = 1'b1;
        send_frame(HEAD_CONTROL, 18, 1'b1, 1'b0);
      end
      // Quiet stretch with no idling on either side.
      no_gaps = (random_sent >= 160 && random_sent < 240);
      // Sender pause: drop valid and let every owed event drain first.
      if (random_sent >= 260 && random_sent < 290) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (pending_events.size() != 0) @(posedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        random_sent = 290;
      end

      pick = $urandom_range(0, 99);
      items_sent = 0;
      if (pick < 45) begin
        send_frame(HEAD_CONTROL, $urandom_range(18, 20), 1'b1,
                   ($urandom_range(0, 9) == 0));
      end else if (pick < 60) begin
        send_frame(HEAD_CONTROL, $urandom_range(3, 17), 1'b0, 1'b0);
      end else if (pick < 70) begin
        send_frame(HEAD_CONFIG, $urandom_range(3, 20), 1'b0, 1'b0);
      end else if (pick < 80) begin
        // Head followed by a length out of range.
        send_byte($urandom_range(0, 1) ? HEAD_CONTROL : HEAD_CONFIG, 1'b0, '0);
        send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 2))
                                       : 8'($urandom_range(21, 255)), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
      random_sent += items_sent;
    end

    // Drop valid, wait for every owed event, then let the block settle.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    no_gaps    = 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("crc_checked_frame_receiver_top_test: PASS");
    end else begin
      $display("crc_checked_frame_receiver_top_test: FAIL");
    end
    $finish;
  end

endmodule
